@@ design/bwsd_pkg.sv @@
// Shared types, status codes and tag decode tables for the word stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package bwsd_pkg;

    localparam int unsigned NumTags = 40;

    // Result status codes.
    localparam logic [2:0] ST_INST        = 3'd0;
    localparam logic [2:0] ST_END         = 3'd1;
    localparam logic [2:0] ST_BAD_TAG     = 3'd2;
    localparam logic [2:0] ST_MISSING_ARG = 3'd3;
    localparam logic [2:0] ST_PUSH_RANGE  = 3'd4;
    localparam logic [2:0] ST_CHAR_BIG    = 3'd5;

    // Instruction kinds and tags that need special handling.
    localparam logic [5:0] K_PRINT_CHAR   = 6'd2;
    localparam logic [5:0] K_PUSH_INT     = 6'd3;
    localparam logic [5:0] TAG_PRINT_CHAR = 6'd2;
    localparam logic [5:0] TAG_PUSH_NEG   = 6'd3;
    localparam logic [5:0] TAG_PUSH_POS   = 6'd4;

    typedef struct packed {
        logic [63:0] word;
        logic        end_of_stream;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  opcode;
        logic [63:0] arg_first;
        logic [63:0] arg_second;
        logic        is_label;
        logic [31:0] inst_index;
    } t_out_req;

    typedef struct packed {
        logic [1:0]  args_remaining;
        logic [5:0]  pending_tag;
        logic [63:0] first_arg_hold;
        logic [31:0] inst_count;
        logic        halted;
    } t_dec_state;

    // Tag to instruction kind; tags outside the table never reach here.
    function automatic logic [5:0] tag_kind(input logic [5:0] tag);
        logic [5:0] k;
        case (tag) inside
            [6'd0:6'd3]:   k = tag;
            [6'd4:6'd20]:  k = tag - 6'd1;
            6'd21:         k = 6'd19;
            6'd22, 6'd23:  k = 6'd20;
            6'd24, 6'd25:  k = 6'd21;
            [6'd26:6'd28]: k = tag - 6'd4;
            [6'd29:6'd36]: k = tag - 6'd5;
            6'd37, 6'd38:  k = 6'd31;
            6'd39:         k = 6'd32;
            default:       k = 6'd0;
        endcase
        return k;
    endfunction

    // Number of argument words that follow each tag.
    function automatic logic [1:0] tag_args(input logic [5:0] tag);
        logic [1:0] n;
        case (tag) inside
            6'd5:                                   n = 2'd2;
            [6'd1:6'd4], 6'd6, 6'd7, 6'd9, 6'd10,
            [6'd19:6'd25], 6'd28, 6'd29,
            [6'd36:6'd38]:                          n = 2'd1;
            default:                                n = 2'd0;
        endcase
        return n;
    endfunction

    // Tags whose target is a label rather than an address.
    function automatic logic tag_label(input logic [5:0] tag);
        logic l;
        case (tag) inside
            6'd20, 6'd22, 6'd24, 6'd28: l = 1'b1;
            default:                    l = 1'b0;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

@@ design/bwsd_decode.sv @@
// Combinational decode of one word against the current gather state.
`timescale 1ns / 1ps
`default_nettype none

module bwsd_decode
    import bwsd_pkg::*;
(
    input  var t_in_req    i_req,
    input  var t_dec_state i_state,
    output logic           o_emit,
    output t_out_req       o_res,
    output t_dec_state     o_state
);

    logic [5:0]  tag;
    logic [1:0]  nargs;
    logic        big_neg;

    assign big_neg = i_req.word[63] && (|i_req.word[62:0]);

    always_comb begin
        o_emit  = 1'b0;
        o_res   = '0;
        o_res.inst_index = i_state.inst_count;
        o_state = i_state;
        tag     = i_state.pending_tag;
        nargs   = tag_args(i_state.pending_tag);

        if (i_req.end_of_stream) begin
            if (!i_state.halted) begin
                o_emit = 1'b1;
                if (i_state.args_remaining != 2'd0) begin
                    o_res.status = ST_MISSING_ARG;
                    o_res.opcode = tag_kind(i_state.pending_tag);
                end else begin
                    o_res.status = ST_END;
                end
            end
            o_state = '0;
        end else if (i_state.halted) begin
            o_emit = 1'b0;
        end else if (i_state.args_remaining == 2'd0) begin
            tag   = i_req.word[5:0];
            nargs = tag_args(tag);
            if (i_req.word >= 64'(NumTags)) begin
                o_emit                 = 1'b1;
                o_res.status           = ST_BAD_TAG;
                o_res.arg_first        = i_req.word;
                o_state.halted         = 1'b1;
                o_state.args_remaining = 2'd0;
            end else if (nargs == 2'd0) begin
                o_emit                 = 1'b1;
                o_res.status           = ST_INST;
                o_res.opcode           = tag_kind(tag);
                o_res.is_label         = tag_label(tag);
                o_state.inst_count     = i_state.inst_count + 32'd1;
            end else begin
                o_state.pending_tag    = tag;
                o_state.args_remaining = nargs;
            end
        end else if (i_state.args_remaining == 2'd2) begin
            o_state.first_arg_hold = i_req.word;
            o_state.args_remaining = 2'd1;
        end else begin
            // Last argument word: range checks, then the finished instruction.
            o_emit                 = 1'b1;
            o_state.args_remaining = 2'd0;
            o_res.opcode           = tag_kind(tag);
            o_res.is_label         = tag_label(tag);
            o_res.arg_first        = i_req.word;
            if ((tag == TAG_PUSH_NEG && big_neg) || (tag == TAG_PUSH_POS && i_req.word[63])) begin
                o_res.status   = ST_PUSH_RANGE;
                o_res.opcode   = K_PUSH_INT;
                o_res.is_label = 1'b0;
                o_state.halted = 1'b1;
            end else if (tag == TAG_PRINT_CHAR && (|i_req.word[63:7])) begin
                o_res.status   = ST_CHAR_BIG;
                o_res.opcode   = K_PRINT_CHAR;
                o_res.is_label = 1'b0;
                o_state.halted = 1'b1;
            end else begin
                o_res.status       = ST_INST;
                o_state.inst_count = i_state.inst_count + 32'd1;
                if (nargs == 2'd2) begin
                    o_res.arg_first  = i_state.first_arg_hold;
                    o_res.arg_second = i_req.word;
                end else if (tag == TAG_PUSH_NEG) begin
                    o_res.arg_first = 64'd0 - i_req.word;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/bytecode_word_stream_decoder_top.sv @@
// Top level of the word stream decoder: input register, decode, state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_req: word, eos)
// output    | out       | o_out_valid / i_out_stall | o_out_data (t_out_req: decoded item)
//
// One request is accepted in every cycle while the result side keeps draining.
// A request is decoded combinationally while it sits in the input register, and
// its result, if any, is then loaded into the result register and shown from there;
// a single decode stage lies between the two registers. Reset is synchronous and
// active low; it empties both registers and clears the gather state. A stall on
// the output holds the result register and backs up into the input register,
// which then raises o_in_stall.

module bytecode_word_stream_decoder_top
    import bwsd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  var t_in_req i_in_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_req    o_out_data
);

    // Input register holding the request waiting to be decoded.
    logic       r_in_valid;
    logic       n_in_valid;
    t_in_req    r_in_data;

    // Result register and gather state.
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_req   r_out_data;
    t_dec_state r_state;

    logic       dec_emit;
    t_out_req   dec_res;
    t_dec_state dec_state;

    logic       in_take;
    logic       advance;

    // The held request moves on whenever the result register can take a result;
    // a request that makes no result still waits for that slot, which keeps the
    // order simple, though an output stall then holds such a request as well.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bwsd_decode u_decode (
        .i_req   (r_in_data),
        .i_state (r_state),
        .o_emit  (dec_emit),
        .o_res   (dec_res),
        .o_state (dec_state)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance && dec_emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= dec_state;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (advance && dec_emit) begin
            r_out_data <= dec_res;
        end
    end

    // An error leaves nothing half gathered.
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> r_state.args_remaining == 2'd0)
        else $error("halted with arguments still pending");

    // A pending tag is always one of the known tags.
    a_pending_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.args_remaining != 2'd0 |-> r_state.pending_tag < 6'(NumTags))
        else $error("pending tag out of range");

    // Each decoded instruction advances the counter by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && dec_emit && dec_res.status == ST_INST
        |=> r_state.inst_count == 32'($past(r_state.inst_count) + 32'd1))
        else $error("instruction counter did not advance");

    // A finished result is never overwritten while it waits on a stall.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !advance)
        else $error("result register overrun");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the word stream decoder: random programs, random stalls, scoreboard.

module tb_top;
    import bwsd_pkg::*;

    // Tags the stimulus names directly; the rest are picked at random.
    localparam logic [5:0] TAG_CONSTRUCT  = 6'd5;
    localparam logic [5:0] TAG_JUMP_LABEL = 6'd20;

    // Bit n is set when tag n is followed by exactly one argument word.
    // The construct tag is the only one that takes two.
    localparam logic [39:0] ONE_ARG_TAGS = 40'h70_33F8_06DE;
    // Bit n is set when tag n names its target by label.
    localparam logic [39:0] LABEL_TAGS   = 40'h00_1150_0000;

    localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES   = {64{1'b1}};
    localparam logic [63:0] CHAR_LIMIT = 64'd127;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 10;
    localparam int TIMEOUT_NS      = 10_000_000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    t_in_req  req_data  = '0;
    logic     res_stall = 1'b0;
    wire      req_stall;
    wire      res_valid;
    t_out_req res_data;

    bytecode_word_stream_decoder_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder prediction. This keeps its own copy of the gather state,
    // which starts at the reset value since reset is applied only once.
    // ------------------------------------------------------------------
    logic [1:0]  args_left  = '0;
    logic [5:0]  held_tag   = '0;
    logic [63:0] held_first = '0;
    logic [31:0] inst_no    = '0;
    logic        halted     = 1'b0;

    t_out_req pending_results[$];
    int       mismatch_count = 0;

    // Kinds are numbered densely in tag order, so the kind of a tag is the
    // tag minus the number of tags up to it that repeat the previous kind
    // (4, 21, 23, 25, 29, 37 and 38).
    function automatic logic [5:0] kind_of(input logic [5:0] tag);
        logic [5:0] k;
        k = tag;
        if (tag >= 6'd4)  k = k - 6'd1;
        if (tag >= 6'd21) k = k - 6'd1;
        if (tag >= 6'd23) k = k - 6'd1;
        if (tag >= 6'd25) k = k - 6'd1;
        if (tag >= 6'd29) k = k - 6'd1;
        if (tag >= 6'd37) k = k - 6'd1;
        if (tag >= 6'd38) k = k - 6'd1;
        return k;
    endfunction

    task automatic push_result(input logic [2:0] st, input logic [5:0] op,
                               input logic [63:0] a, input logic [63:0] b,
                               input logic lab);
        t_out_req r;
        r.status     = st;
        r.opcode     = op;
        r.arg_first  = a;
        r.arg_second = b;
        r.is_label   = lab;
        r.inst_index = inst_no;
        pending_results.push_back(r);
    endtask

    // A decoded instruction takes the current index and then bumps it.
    task automatic finish_instruction(input logic [5:0] tag, input logic [63:0] a,
                                      input logic [63:0] b);
        push_result(ST_INST, kind_of(tag), a, b, LABEL_TAGS[tag]);
        inst_no   = inst_no + 32'd1;
        args_left = 2'd0;
    endtask

    // Any error stops decoding until the next end of stream.
    task automatic raise_error(input logic [2:0] st, input logic [5:0] op,
                               input logic [63:0] w);
        push_result(st, op, w, '0, 1'b0);
        halted    = 1'b1;
        args_left = 2'd0;
    endtask

    task automatic decode_request(input t_in_req req);
        logic [5:0] tag;
        tag = held_tag;
        if (req.end_of_stream) begin
            // An end while halted is silent; otherwise it either closes the
            // program or reports the instruction that was cut short.
            if (!halted) begin
                if (args_left != 2'd0) begin
                    push_result(ST_MISSING_ARG, kind_of(held_tag), '0, '0, 1'b0);
                end else begin
                    push_result(ST_END, '0, '0, '0, 1'b0);
                end
            end
            args_left  = '0;
            held_tag   = '0;
            held_first = '0;
            inst_no    = '0;
            halted     = 1'b0;
        end else if (halted) begin
            // Words after an error are dropped without a trace.
        end else if (args_left == 2'd0) begin
            if (req.word >= 64'(NumTags)) begin
                raise_error(ST_BAD_TAG, '0, req.word);
            end else begin
                tag = req.word[5:0];
                if (tag == TAG_CONSTRUCT) begin
                    held_tag  = tag;
                    args_left = 2'd2;
                end else if (ONE_ARG_TAGS[tag]) begin
                    held_tag  = tag;
                    args_left = 2'd1;
                end else begin
                    finish_instruction(tag, '0, '0);
                end
            end
        end else if (args_left == 2'd2) begin
            held_first = req.word;
            args_left  = 2'd1;
        end else if (tag == TAG_CONSTRUCT) begin
            finish_instruction(tag, held_first, req.word);
        end else if (tag == TAG_PUSH_NEG && req.word > SIGN_BIT) begin
            raise_error(ST_PUSH_RANGE, K_PUSH_INT, req.word);
        end else if (tag == TAG_PUSH_NEG) begin
            finish_instruction(tag, 64'd0 - req.word, '0);
        end else if (tag == TAG_PUSH_POS && req.word[63]) begin
            raise_error(ST_PUSH_RANGE, K_PUSH_INT, req.word);
        end else if (tag == TAG_PRINT_CHAR && req.word > CHAR_LIMIT) begin
            raise_error(ST_CHAR_BIG, K_PRINT_CHAR, req.word);
        end else begin
            finish_instruction(tag, req.word, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus. Programs are lists of requests; most are well formed so
    // that long instruction runs are decoded, and a share of them end in
    // a truncated instruction or a bad tag followed by junk.
    // ------------------------------------------------------------------
    t_in_req request_queue[$];
    int      ignored_words = 0;

    task automatic queue_word(input logic [63:0] w);
        t_in_req r;
        r.word          = w;
        r.end_of_stream = 1'b0;
        request_queue.push_back(r);
    endtask

    // The word of an end of stream is ignored, so it carries random bits.
    task automatic queue_end();
        t_in_req r;
        r.word          = {$urandom, $urandom};
        r.end_of_stream = 1'b1;
        request_queue.push_back(r);
    endtask

    // Arguments lean on the range boundaries of the checked tags.
    function automatic logic [63:0] pick_arg(input logic [5:0] tag);
        logic [63:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = ALL_ONES;
            2:       v = SIGN_BIT;
            3:       v = SIGN_BIT - 64'd1;
            4:       v = SIGN_BIT + 64'd1;
            5:       v = CHAR_LIMIT;
            6:       v = CHAR_LIMIT + 64'd1;
            7, 8, 9: v = 64'($urandom_range(0, 255));
            default: v = {$urandom, $urandom};
        endcase
        // Keep most checked arguments legal so the program keeps going.
        if ($urandom_range(0, 9) < 8) begin
            if (tag == TAG_PRINT_CHAR) begin
                v = {57'd0, v[6:0]};
            end else if ((tag == TAG_PUSH_NEG || tag == TAG_PUSH_POS) && v != SIGN_BIT) begin
                v[63] = 1'b0;
            end
        end
        return v;
    endfunction

    task automatic queue_instruction(input logic [5:0] tag);
        queue_word(64'(tag));
        if (tag == TAG_CONSTRUCT) begin
            queue_word(pick_arg(tag));
            queue_word(pick_arg(tag));
        end else if (ONE_ARG_TAGS[tag]) begin
            queue_word(pick_arg(tag));
        end
    endtask

    task automatic queue_program();
        int          n_inst;
        int unsigned shape;
        logic [5:0]  tag;
        logic [63:0] bad;
        n_inst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        shape  = $urandom_range(0, 99);
        for (int i = 0; i < n_inst; i++) begin
            queue_instruction(6'($urandom_range(0, NumTags - 1)));
        end
        if (shape < 12) begin
            // The stream ends before the last instruction has all its words.
            do tag = 6'($urandom_range(0, NumTags - 1));
            while (!(ONE_ARG_TAGS[tag] || tag == TAG_CONSTRUCT));
            queue_word(64'(tag));
            if (tag == TAG_CONSTRUCT && $urandom_range(0, 1) == 1) begin
                queue_word(pick_arg(tag));
            end
        end else if (shape < 22) begin
            // A bad tag halts the decoder; the junk behind it is dropped.
            case ($urandom_range(0, 2))
                0:       bad = 64'(NumTags);
                1:       bad = ALL_ONES;
                default: bad = {$urandom, $urandom};
            endcase
            if (bad < 64'(NumTags)) bad = bad + 64'(NumTags);
            queue_word(bad);
            repeat ($urandom_range(0, 4)) begin
                queue_word(($urandom_range(0, 1) == 1) ? {$urandom, $urandom}
                                                       : 64'($urandom_range(0, NumTags - 1)));
                ignored_words++;
            end
        end
        queue_end();
        // Now and then a second end right away, an empty program.
        if ($urandom_range(0, 19) == 0) queue_end();
    endtask

    // Idle lengths: mostly none or short, a few long.
    function automatic int pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request driver. It changes its outputs on the falling edge only, and
    // only once the request it shows has been taken, so a stalled request
    // holds still. After each request it may idle for a random gap, with
    // calm stretches in which requests go back to back.
    // ------------------------------------------------------------------
    logic req_taken = 1'b0;
    int   gap_left  = 0;
    int   calm_left = 0;

    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_taken)) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                req_data  <= request_queue.pop_front();
                req_valid <= 1'b1;
                if (calm_left > 0) begin
                    calm_left <= calm_left - 1;
                    gap_left  <= 0;
                end else begin
                    gap_left <= pick_idle();
                    if ($urandom_range(0, 49) == 0) calm_left <= $urandom_range(20, 100);
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink. Stall rises at random for random lengths, with long
    // calm stretches where every result is taken at once.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int sink_calm  = 0;

    always @(negedge clk) begin
        if (stall_left > 0) begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (sink_calm > 0) begin
            res_stall <= 1'b0;
            sink_calm <= sink_calm - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            res_stall  <= 1'b1;
            stall_left <= pick_idle();
        end else begin
            res_stall <= 1'b0;
            if ($urandom_range(0, 199) == 0) sink_calm <= $urandom_range(50, 300);
        end
    end

    // ------------------------------------------------------------------
    // Monitor. On each rising edge an accepted request is run through the
    // prediction first, then an accepted result is checked against the
    // oldest expectation. Values are read before the edge's updates land.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        t_out_req want;
        if (rst_n && req_valid && !req_stall) decode_request(req_data);
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result st=%0d op=%0d a=%h b=%h lab=%0b idx=%0d",
                             res_data.status, res_data.opcode, res_data.arg_first,
                             res_data.arg_second, res_data.is_label, res_data.inst_index);
                end
            end else begin
                want = pending_results.pop_front();
                if (res_data.status !== want.status || res_data.opcode !== want.opcode ||
                    res_data.arg_first !== want.arg_first ||
                    res_data.arg_second !== want.arg_second ||
                    res_data.is_label !== want.is_label ||
                    res_data.inst_index !== want.inst_index) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch want st=%0d op=%0d a=%h b=%h lab=%0b idx=%0d",
                                 want.status, want.opcode, want.arg_first,
                                 want.arg_second, want.is_label, want.inst_index);
                        $display("         got  st=%0d op=%0d a=%h b=%h lab=%0b idx=%0d",
                                 res_data.status, res_data.opcode, res_data.arg_first,
                                 res_data.arg_second, res_data.is_label, res_data.inst_index);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence: directed programs, then random ones, then reset is
    // released and the bench waits for every request and result to pass.
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int start_size;

        // An empty program reports the end with index zero.
        queue_end();
        // Construct with extreme arguments, the edges of both push tags and
        // of print_char, and a label jump, then a normal end.
        queue_word(64'(TAG_CONSTRUCT));
        queue_word(ALL_ONES);
        queue_word('0);
        queue_word(64'(TAG_PUSH_NEG));
        queue_word(SIGN_BIT);
        queue_word(64'(TAG_PUSH_POS));
        queue_word(SIGN_BIT - 64'd1);
        queue_word(64'(TAG_PRINT_CHAR));
        queue_word(CHAR_LIMIT);
        queue_word(64'(TAG_JUMP_LABEL));
        queue_word(ALL_ONES);
        queue_word(64'(NumTags - 1));
        queue_end();
        // Negated push just out of range; the next word is ignored and the
        // end while halted gives no result.
        queue_word(64'(TAG_PUSH_NEG));
        queue_word(SIGN_BIT + 64'd1);
        queue_word(ALL_ONES);
        queue_end();
        // Positive push at the sign bit is out of range.
        queue_word(64'(TAG_PUSH_POS));
        queue_word(SIGN_BIT);
        queue_end();
        // Character one above the limit.
        queue_word(64'(TAG_PRINT_CHAR));
        queue_word(CHAR_LIMIT + 64'd1);
        queue_end();
        // The first tag past the table.
        queue_word(64'(NumTags));
        queue_end();
        // End of stream between the two construct arguments.
        queue_word(64'(TAG_CONSTRUCT));
        queue_word(SIGN_BIT);
        queue_end();

        start_size = request_queue.size();
        while (int'(request_queue.size()) - ignored_words - start_size < RANDOM_REQUESTS) begin
            queue_program();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req_valid) @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
